@@ hw/rtl/mfr_pkg.sv @@
// Package for the mesh flooding relay with duplicate suppression.
// Holds the cache depth, field widths, request codes and the probe word type.
// Has no dependencies; every other file in this block imports it.
package mfr_pkg;

    localparam int CACHE_DEPTH = 128;
    localparam int FILL_W      = $clog2(CACHE_DEPTH + 1);
    localparam int UID_W       = 32;
    localparam int TTL_W       = 8;
    localparam int COUNT_W     = 32;

    localparam logic [TTL_W-1:0] DEFAULT_TTL_RESET = 8'd32;

    localparam logic REQ_RX    = 1'b0;
    localparam logic REQ_LOCAL = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [FILL_W-1:0] remaining;
    } probe_t;

endpackage

@@ hw/rtl/mfr_cell.sv @@
// One cache cell: holds one uid and one stage of the lookup probe.
// Depends on mfr_pkg for widths and the probe word type.
module mfr_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift_en,
    input  logic [mfr_pkg::UID_W-1:0] uid_in,
    output logic [mfr_pkg::UID_W-1:0] uid_out,
    input  logic [mfr_pkg::UID_W-1:0] key,
    input  mfr_pkg::probe_t      probe_in,
    output mfr_pkg::probe_t      probe_out
);
    import mfr_pkg::*;

    logic [UID_W-1:0] entry_reg;
    probe_t           probe_reg;
    probe_t           probe_next;
    logic             live;

    assign live = probe_in.remaining != '0;

    always_comb
    begin
        probe_next.valid     = probe_in.valid;
        probe_next.hit       = probe_in.hit | (probe_in.valid & live & (entry_reg == key));
        probe_next.remaining = live ? probe_in.remaining - FILL_W'(1) : probe_in.remaining;
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= uid_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    assign uid_out   = entry_reg;
    assign probe_out = probe_reg;

endmodule

@@ hw/rtl/mfr_chain.sv @@
// Row of cache cells: uids shift in at the head, the oldest falls off the tail.
// The lookup probe walks from head to tail one cell per cycle. Uses mfr_pkg, mfr_cell.
module mfr_chain (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift_en,
    input  logic [mfr_pkg::UID_W-1:0] shift_uid,
    input  logic [mfr_pkg::UID_W-1:0] key,
    input  mfr_pkg::probe_t      probe_in,
    output mfr_pkg::probe_t      probe_out
);
    import mfr_pkg::*;

    logic [UID_W-1:0] uid_link [0:CACHE_DEPTH];
    probe_t           probe_link [0:CACHE_DEPTH];

    assign uid_link[0]   = shift_uid;
    assign probe_link[0] = probe_in;

    for (genvar i = 0; i < CACHE_DEPTH; i++)
    begin : g_cell
        mfr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_en  (shift_en),
            .uid_in    (uid_link[i]),
            .uid_out   (uid_link[i+1]),
            .key       (key),
            .probe_in  (probe_link[i]),
            .probe_out (probe_link[i+1])
        );
    end

    assign probe_out = probe_link[CACHE_DEPTH];

endmodule

@@ hw/rtl/mesh_flood_relay_dedup_cache_top.sv @@
// Top level of the mesh flooding relay with duplicate suppression.
// Holds the control sequencer, counters and output register. Uses mfr_pkg, mfr_chain.
//
// The block takes one word at a time. A local send goes from acceptance straight to the
// finish state. A received packet passes through the search state first, because its uid
// is compared against the cache by a probe that walks the row of cache cells one cell per
// cycle. An input word is still accepted while a finished result waits at the output
// register; the cache is only updated once that result is written.
module mesh_flood_relay_dedup_cache_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mfr_pkg::TTL_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [mfr_pkg::UID_W-1:0]     pkt_uid,
    input  logic [mfr_pkg::TTL_W-1:0]     pkt_ttl,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          emit,
    output logic [mfr_pkg::UID_W-1:0]     out_uid,
    output logic [mfr_pkg::TTL_W-1:0]     out_ttl,
    output logic                          duplicate,
    output logic [mfr_pkg::COUNT_W-1:0]   received_count
);
    import mfr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [TTL_W-1:0]    default_ttl_reg;
    logic                req_reg;
    logic [UID_W-1:0]    uid_reg;
    logic [TTL_W-1:0]    ttl_reg;
    logic                start_reg, start_next;
    logic                hit_reg, hit_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic                emit_reg, emit_next;
    logic [UID_W-1:0]    out_uid_reg, out_uid_next;
    logic [TTL_W-1:0]    out_ttl_reg, out_ttl_next;
    logic                dup_reg, dup_next;

    logic                in_accept;
    logic                out_free;
    logic                finish;
    logic                is_local;
    logic                insert;
    probe_t              probe_head;
    probe_t              probe_tail;

    assign cfg_ready = 1'b1;
    assign in_stall  = state_reg != ST_IDLE;
    assign in_accept = in_valid & ~in_stall;
    assign out_free  = ~out_valid_reg | ~out_stall;
    assign finish    = (state_reg == ST_FINISH) & out_free;
    assign is_local  = req_reg == REQ_LOCAL;
    assign insert    = finish & (is_local | ~hit_reg);

    assign probe_head.valid     = start_reg;
    assign probe_head.hit       = 1'b0;
    assign probe_head.remaining = fill_reg;

    mfr_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (insert),
        .shift_uid (uid_reg),
        .key       (uid_reg),
        .probe_in  (probe_head),
        .probe_out (probe_tail)
    );

    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        hit_next       = hit_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg & out_stall;
        emit_next      = emit_reg;
        out_uid_next   = out_uid_reg;
        out_ttl_next   = out_ttl_reg;
        dup_next       = dup_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    hit_next = 1'b0;
                    if (req_type == REQ_LOCAL)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                        start_next = 1'b1;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (probe_tail.valid)
                begin
                    hit_next   = probe_tail.hit;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (is_local)
                    begin
                        emit_next    = 1'b1;
                        out_uid_next = uid_reg;
                        out_ttl_next = default_ttl_reg;
                        dup_next     = 1'b0;
                    end
                    else if (hit_reg)
                    begin
                        emit_next    = 1'b0;
                        out_uid_next = '0;
                        out_ttl_next = '0;
                        dup_next     = 1'b1;
                    end
                    else
                    begin
                        count_next   = count_reg + COUNT_W'(1);
                        dup_next     = 1'b0;
                        emit_next    = ttl_reg != '0;
                        out_uid_next = (ttl_reg != '0) ? uid_reg : '0;
                        out_ttl_next = (ttl_reg != '0) ? ttl_reg - TTL_W'(1) : '0;
                    end
                    if (fill_reg != FILL_W'(CACHE_DEPTH) && (is_local || !hit_reg))
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            default_ttl_reg <= DEFAULT_TTL_RESET;
            req_reg         <= REQ_RX;
            uid_reg         <= '0;
            ttl_reg         <= '0;
            start_reg       <= 1'b0;
            hit_reg         <= 1'b0;
            fill_reg        <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            emit_reg        <= 1'b0;
            out_uid_reg     <= '0;
            out_ttl_reg     <= '0;
            dup_reg         <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            hit_reg       <= hit_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            emit_reg      <= emit_next;
            out_uid_reg   <= out_uid_next;
            out_ttl_reg   <= out_ttl_next;
            dup_reg       <= dup_next;
            if (cfg_valid && cfg_ready)
            begin
                default_ttl_reg <= cfg_data;
            end
            if (in_accept)
            begin
                req_reg <= req_type;
                uid_reg <= pkt_uid;
                ttl_reg <= pkt_ttl;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign emit           = emit_reg;
    assign out_uid        = out_uid_reg;
    assign out_ttl        = out_ttl_reg;
    assign duplicate      = dup_reg;
    assign received_count = count_reg;

endmodule

@@ bench/mesh_flood_relay_dedup_cache_top_tb.sv @@
// Self-checking bench for the flooding relay with duplicate suppression.
// Holds a word-level predictor of the uid cache, a driver, a monitor and a watchdog.
// Depends on mfr_pkg and mesh_flood_relay_dedup_cache_top.
module mesh_flood_relay_dedup_cache_top_tb;
    import mfr_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_WAIT  = 300;
    localparam int PHASE_WORDS  = 600;
    localparam int UID_POOL     = 300;
    localparam int REUSE_REACH  = 160;

    typedef struct packed {
        logic             req;
        logic [UID_W-1:0] uid;
        logic [TTL_W-1:0] ttl;
    } pkt_word_t;

    typedef struct packed {
        logic               emit;
        logic [UID_W-1:0]   uid;
        logic [TTL_W-1:0]   ttl;
        logic               dup;
        logic [COUNT_W-1:0] count;
    } relay_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [TTL_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 req_type = REQ_RX;
    logic [UID_W-1:0]     pkt_uid = '0;
    logic [TTL_W-1:0]     pkt_ttl = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 emit;
    logic [UID_W-1:0]     out_uid;
    logic [TTL_W-1:0]     out_ttl;
    logic                 duplicate;
    logic [COUNT_W-1:0]   received_count;

    pkt_word_t            pending_words[$];
    relay_result_t        expected_results[$];
    logic [UID_W-1:0]     uid_history[$];

    logic [UID_W-1:0]     seen_uids[CACHE_DEPTH];
    int                   seen_fill = 0;
    int                   seen_head = 0;
    logic [COUNT_W-1:0]   new_rx_count = '0;
    logic [TTL_W-1:0]     local_ttl = DEFAULT_TTL_RESET;

    int                   gap_pct = 0;
    int                   stall_pct = 0;
    int                   fault_count = 0;
    int                   idle_cycles = 0;
    int                   rx_words = 0;
    int                   local_words = 0;
    int                   dup_words = 0;
    int                   relayed_words = 0;
    int                   results_checked = 0;

    mesh_flood_relay_dedup_cache_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .pkt_uid        (pkt_uid),
        .pkt_ttl        (pkt_ttl),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .emit           (emit),
        .out_uid        (out_uid),
        .out_ttl        (out_ttl),
        .duplicate      (duplicate),
        .received_count (received_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void cache_uid(logic [UID_W-1:0] uid);
        if (seen_fill < CACHE_DEPTH)
        begin
            seen_uids[(seen_head + seen_fill) % CACHE_DEPTH] = uid;
            seen_fill++;
        end
        else
        begin
            seen_uids[seen_head] = uid;
            seen_head = (seen_head + 1) % CACHE_DEPTH;
        end
    endfunction

    function automatic relay_result_t relay_predict(pkt_word_t w);
        relay_result_t r;
        logic          hit;
        int            k;
        r   = '0;
        hit = 1'b0;
        if (w.req == REQ_LOCAL)
        begin
            cache_uid(w.uid);
            r.emit = 1'b1;
            r.uid  = w.uid;
            r.ttl  = local_ttl;
            local_words++;
        end
        else
        begin
            rx_words++;
            for (k = 0; k < seen_fill; k++)
                if (seen_uids[(seen_head + k) % CACHE_DEPTH] == w.uid)
                    hit = 1'b1;
            if (hit)
            begin
                r.dup = 1'b1;
                dup_words++;
            end
            else
            begin
                new_rx_count = new_rx_count + 1'b1;
                cache_uid(w.uid);
                if (w.ttl != '0)
                begin
                    r.emit = 1'b1;
                    r.uid  = w.uid;
                    r.ttl  = w.ttl - 1'b1;
                    relayed_words++;
                end
            end
        end
        r.count = new_rx_count;
        return r;
    endfunction

    function automatic pkt_word_t random_word(logic [UID_W-1:0] pool_base);
        pkt_word_t w;
        int        pick;
        int        reach;
        pick  = $urandom_range(99);
        w.req = (pick < 15) ? REQ_LOCAL : REQ_RX;
        w.ttl = TTL_W'($urandom_range(255));
        if ($urandom_range(9) == 0)
            w.ttl = '0;
        else if ($urandom_range(9) == 0)
            w.ttl = 8'd1;
        else if ($urandom_range(19) == 0)
            w.ttl = 8'hFF;
        if (pick < 50 && uid_history.size() != 0)
        begin
            reach = (uid_history.size() > REUSE_REACH) ? REUSE_REACH : uid_history.size() - 1;
            w.uid = uid_history[uid_history.size() - 1 - $urandom_range(reach)];
        end
        else if (pick < 85)
            w.uid = pool_base + $urandom_range(UID_POOL - 1);
        else
            w.uid = $urandom;
        uid_history = {uid_history, w.uid};
        if (uid_history.size() > 400)
            void'(uid_history.pop_front());
        return w;
    endfunction

    task automatic queue_word(logic req, logic [UID_W-1:0] uid, logic [TTL_W-1:0] ttl);
        pkt_word_t w;
        w.req = req;
        w.uid = uid;
        w.ttl = ttl;
        pending_words = {pending_words, w};
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_default_ttl(logic [TTL_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        local_ttl = value;
        @(negedge clk);
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            fault_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_words
        pkt_word_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= REQ_RX;
            pkt_uid  <= '0;
            pkt_ttl  <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                w.req = req_type;
                w.uid = pkt_uid;
                w.ttl = pkt_ttl;
                expected_results = {expected_results, relay_predict(w)};
            end
            if (pending_words.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                w = pending_words.pop_front();
                in_valid <= 1'b1;
                req_type <= w.req;
                pkt_uid  <= w.uid;
                pkt_ttl  <= w.ttl;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        relay_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word arrived with none pending");
                fault_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("emit", 32'(want.emit), 32'(emit));
                check_field("out_uid", want.uid, out_uid);
                check_field("out_ttl", 32'(want.ttl), 32'(out_ttl));
                check_field("duplicate", 32'(want.dup), 32'(duplicate));
                check_field("received_count", want.count, received_count);
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("mesh_flood_relay_dedup_cache_top_tb: errors");
            $finish;
        end
    end

    initial
    begin
        logic [UID_W-1:0] pool_base;
        int               phase;
        int               n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_word(REQ_LOCAL, 32'h0000_0000, 8'hFF);
        queue_word(REQ_RX,    32'h0000_0000, 8'h00);
        queue_word(REQ_RX,    32'hFFFF_FFFF, 8'hFF);
        queue_word(REQ_RX,    32'hFFFF_FFFF, 8'h01);
        queue_word(REQ_RX,    32'h0000_0001, 8'h00);
        queue_word(REQ_RX,    32'h0000_0001, 8'h05);
        queue_word(REQ_RX,    32'h0000_0002, 8'h01);
        queue_word(REQ_LOCAL, 32'hFFFF_FFFF, 8'h00);
        queue_word(REQ_RX,    32'hA5A5_A5A5, 8'h80);
        queue_word(REQ_RX,    32'h5A5A_5A5A, 8'h7F);
        queue_word(REQ_LOCAL, 32'h5A5A_5A5A, 8'h55);
        wait_idle();
        write_default_ttl(8'h00);
        queue_word(REQ_LOCAL, 32'h0000_0003, 8'hAA);
        queue_word(REQ_RX,    32'h0000_0003, 8'h09);
        wait_idle();
        write_default_ttl(8'hFF);
        queue_word(REQ_LOCAL, 32'h0000_0004, 8'h00);
        queue_word(REQ_RX,    32'h0000_0006, 8'hFF);
        wait_idle();

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    write_default_ttl(TTL_W'($urandom_range(2, 254)));
                    gap_pct   = 35;
                    stall_pct = 54;
                end
                1:
                begin
                    write_default_ttl(8'h01);
                    gap_pct   = 54;
                    stall_pct = 35;
                end
                default:
                begin
                    write_default_ttl(TTL_W'($urandom_range(255)));
                    gap_pct   = 0;
                    stall_pct = 0;
                end
            endcase
            pool_base = $urandom;
            for (n = 0; n < PHASE_WORDS; n++)
                pending_words = {pending_words, random_word(pool_base)};
            wait_idle();
        end

        repeat (SETTLE_WAIT) @(posedge clk);
        $display("Checked %0d result words: %0d received packets (%0d duplicates), %0d local sends,",
                 results_checked, rx_words, dup_words, local_words);
        $display("%0d relays, cache wrap and eviction under three idling patterns.",
                 relayed_words);
        if (fault_count == 0)
            $display("mesh_flood_relay_dedup_cache_top_tb: clean");
        else
            $display("mesh_flood_relay_dedup_cache_top_tb: errors");
        $finish;
    end
endmodule

@@ mesh_flood_relay_dedup_cache_top.f @@
hw/rtl/mfr_pkg.sv
hw/rtl/mfr_cell.sv
hw/rtl/mfr_chain.sv
hw/rtl/mesh_flood_relay_dedup_cache_top.sv
bench/mesh_flood_relay_dedup_cache_top_tb.sv
